/* src/acir_pkg.sv */
// Package for the IR air-conditioner frame decoder: field widths, configuration
// register indexes, frame byte constants and decoded mode/fan codes.
// No dependencies.
package acir_pkg;

  // Field and register widths
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned FRAME_W  = 64;
  localparam int unsigned TEMP_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACE_THRESHOLD = 2'd0,
    CFG_MIN_ENTRIES     = 2'd1
  } cfg_idx_e;

  // Register reset values
  localparam logic [DUR_W-1:0] SPACE_THRESHOLD_RST = 16'd1250;
  localparam logic [CNT_W-1:0] MIN_ENTRIES_RST     = 8'd131;

  // Bit window inside a capture
  localparam logic [CNT_W-1:0] FIRST_BIT_POS = 8'd4;
  localparam logic [CNT_W-1:0] LAST_BIT_POS  = 8'd130;
  localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;

  // Frame byte constants
  localparam logic [7:0] HDR_BYTE0   = 8'hFF;
  localparam logic [7:0] HDR_BYTE1   = 8'h00;
  localparam logic [7:0] TAIL_BYTE6  = 8'h2A;
  localparam logic [7:0] TAIL_BYTE7  = 8'hD5;
  localparam logic [7:0] FAN_HIGH_B2 = 8'hFF;
  localparam logic [7:0] FAN_MED_B2  = 8'hBF;
  localparam logic [7:0] SUM_BASE    = 8'hFF;
  localparam logic [TEMP_W-1:0] TEMP_BASE = 6'd32;

  // Mode code found in the low three bits of byte4
  localparam logic [2:0] MODE_CODE_COOL = 3'h6;
  localparam logic [2:0] MODE_CODE_DRY  = 3'h5;
  localparam logic [2:0] MODE_CODE_FAN  = 3'h4;
  localparam logic [2:0] MODE_CODE_HEAT = 3'h3;

  // Decoded mode
  typedef enum logic [2:0] {
    MODE_AUTO = 3'd0,
    MODE_COOL = 3'd1,
    MODE_DRY  = 3'd2,
    MODE_FAN  = 3'd3,
    MODE_HEAT = 3'd4
  } mode_e;

  // Decoded fan speed
  typedef enum logic [1:0] {
    FAN_LOW  = 2'd0,
    FAN_MED  = 2'd1,
    FAN_HIGH = 2'd2
  } fan_e;

endpackage

/* src/acir_if.sv */
// Valid/ready channel interfaces of the IR frame decoder: capture entries in,
// decoded frames out, and the configuration write channel. Depends on acir_pkg.

interface acir_in_if;
  logic                          valid;
  logic                          ready;
  logic [acir_pkg::DUR_W-1:0]    duration_ticks;
  logic                          last_of_capture;

  modport source (output valid, duration_ticks, last_of_capture, input ready);
  modport sink   (input valid, duration_ticks, last_of_capture, output ready);
endinterface

interface acir_out_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_ok;
  logic                          length_ok;
  logic                          header_ok;
  logic                          tail_ok;
  logic                          checksum_ok;
  logic                          power_on;
  logic [2:0]                    mode;
  logic [acir_pkg::TEMP_W-1:0]   temperature;
  logic [1:0]                    fan_level;
  logic [acir_pkg::FRAME_W-1:0]  raw_frame;

  modport source (output valid, frame_ok, length_ok, header_ok, tail_ok, checksum_ok,
                  power_on, mode, temperature, fan_level, raw_frame, input ready);
  modport sink   (input valid, frame_ok, length_ok, header_ok, tail_ok, checksum_ok,
                  power_on, mode, temperature, fan_level, raw_frame, output ready);
endinterface

interface acir_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [acir_pkg::CFG_IDX_W-1:0]  index;
  logic [acir_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/ac_ir_frame_decoder.sv */
// Pulse-distance IR frame decoder for an air-conditioner remote; uses acir_pkg and acir_if.sv.
// The result of a final entry is held in the entry register and then loaded into the result register.
// Throughput: one entry per cycle; the input stalls only while a final entry waits in
// the entry register behind a result that is still held.
// Reset (rst_ni low, asynchronous): registers return to 1250 / 131, the capture
// state is cleared and the next entry starts a new capture.
module ac_ir_frame_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  acir_cfg_if.sink          cfg_i,
  acir_in_if.sink           in_i,
  acir_out_if.source        out_o
);

  // Configuration registers
  logic [acir_pkg::DUR_W-1:0] thr_q;
  logic [acir_pkg::CNT_W-1:0] min_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= acir_pkg::SPACE_THRESHOLD_RST;
      min_q <= acir_pkg::MIN_ENTRIES_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        acir_pkg::CFG_SPACE_THRESHOLD: thr_q <= cfg_i.data;
        acir_pkg::CFG_MIN_ENTRIES:     min_q <= cfg_i.data[acir_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry register
  logic                       s1_valid_q;
  logic                       s1_last_q;
  logic [acir_pkg::DUR_W-1:0] s1_dur_q;
  logic                       s1_go;
  logic                       in_fire;

  logic                       out_valid_q;

  // Advance the entry unless it is final and the result slot is blocked
  assign s1_go   = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_dur_q  <= in_i.duration_ticks;
      s1_last_q <= in_i.last_of_capture;
    end
  end

  // Capture state
  logic                         cap_start_q, cap_start_d;
  logic [acir_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [acir_pkg::FRAME_W-1:0] bits_q, bits_d;
  logic [acir_pkg::CNT_W-1:0]   pos;
  logic [acir_pkg::CNT_W-2:0]   bit_off;
  logic [5:0]                   bit_idx;
  logic [acir_pkg::FRAME_W-1:0] bits_base;
  logic                         in_window;

  // Clear on capture start, set the bit of an even position in the window when its duration exceeds the threshold
  always_comb begin
    pos       = cap_start_q ? '0 : cnt_q;
    bits_base = cap_start_q ? '0 : bits_q;
    bit_off   = pos[acir_pkg::CNT_W-1:1] - acir_pkg::FIRST_BIT_POS[acir_pkg::CNT_W-1:1];
    bit_idx   = bit_off[5:0];
    in_window = (pos >= acir_pkg::FIRST_BIT_POS) && (pos <= acir_pkg::LAST_BIT_POS)
                && !pos[0];
    bits_d    = bits_base;
    if (in_window && (s1_dur_q > thr_q)) begin
      bits_d[bit_idx] = 1'b1;
    end
    cnt_d       = (pos == acir_pkg::CNT_MAX) ? pos : pos + 1'b1;
    cap_start_d = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_start_q <= 1'b1;
      cnt_q       <= '0;
      bits_q      <= '0;
    end else if (s1_go) begin
      cap_start_q <= cap_start_d;
      cnt_q       <= cnt_d;
      bits_q      <= bits_d;
    end
  end

  // Frame checks and field decode
  logic [7:0]                  b0, b1, b2, b4, b5, b6, b7;
  logic                        len_ok, hdr_ok, tl_ok, sum_ok, frm_ok;
  acir_pkg::mode_e             mode_dec;
  acir_pkg::fan_e              fan_dec;
  logic [acir_pkg::TEMP_W-1:0] temp_dec;

  always_comb begin
    b0 = bits_d[7:0];
    b1 = bits_d[15:8];
    b2 = bits_d[23:16];
    b4 = bits_d[39:32];
    b5 = bits_d[47:40];
    b6 = bits_d[55:48];
    b7 = bits_d[63:56];
    len_ok = cnt_d >= min_q;
    hdr_ok = (b0 == acir_pkg::HDR_BYTE0) && (b1 == acir_pkg::HDR_BYTE1);
    tl_ok  = (b6 == acir_pkg::TAIL_BYTE6) && (b7 == acir_pkg::TAIL_BYTE7);
    sum_ok = b5 == (acir_pkg::SUM_BASE - b4);
    frm_ok = len_ok && hdr_ok && tl_ok && sum_ok;
    unique case (b4[2:0])
      acir_pkg::MODE_CODE_COOL: mode_dec = acir_pkg::MODE_COOL;
      acir_pkg::MODE_CODE_DRY:  mode_dec = acir_pkg::MODE_DRY;
      acir_pkg::MODE_CODE_FAN:  mode_dec = acir_pkg::MODE_FAN;
      acir_pkg::MODE_CODE_HEAT: mode_dec = acir_pkg::MODE_HEAT;
      default:                  mode_dec = acir_pkg::MODE_AUTO;
    endcase
    if (b2 == acir_pkg::FAN_HIGH_B2) begin
      fan_dec = acir_pkg::FAN_HIGH;
    end else if (b2 == acir_pkg::FAN_MED_B2) begin
      fan_dec = acir_pkg::FAN_MED;
    end else begin
      fan_dec = acir_pkg::FAN_LOW;
    end
    temp_dec = acir_pkg::TEMP_BASE - {2'b00, b4[7:4]};
  end

  // Result register
  logic                         out_frame_ok_q, out_length_ok_q, out_header_ok_q;
  logic                         out_tail_ok_q, out_checksum_ok_q, out_power_on_q;
  logic [2:0]                   out_mode_q;
  logic [acir_pkg::TEMP_W-1:0]  out_temp_q;
  logic [1:0]                   out_fan_q;
  logic [acir_pkg::FRAME_W-1:0] out_raw_q;
  logic                         res_load;

  assign res_load = s1_go && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Zero the fields that a failed check hides
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_frame_ok_q    <= frm_ok;
      out_length_ok_q   <= len_ok;
      out_header_ok_q   <= len_ok && hdr_ok;
      out_tail_ok_q     <= len_ok && tl_ok;
      out_checksum_ok_q <= len_ok && sum_ok;
      out_raw_q         <= len_ok ? bits_d : '0;
      out_power_on_q    <= frm_ok && !b4[3];
      out_mode_q        <= frm_ok ? mode_dec : acir_pkg::MODE_AUTO;
      out_temp_q        <= frm_ok ? temp_dec : '0;
      out_fan_q         <= frm_ok ? fan_dec : acir_pkg::FAN_LOW;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.frame_ok    = out_frame_ok_q;
  assign out_o.length_ok   = out_length_ok_q;
  assign out_o.header_ok   = out_header_ok_q;
  assign out_o.tail_ok     = out_tail_ok_q;
  assign out_o.checksum_ok = out_checksum_ok_q;
  assign out_o.power_on    = out_power_on_q;
  assign out_o.mode        = out_mode_q;
  assign out_o.temperature = out_temp_q;
  assign out_o.fan_level   = out_fan_q;
  assign out_o.raw_frame   = out_raw_q;

  // Checks
  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result appeared without a final entry");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_length_ok_q) |->
      (out_raw_q == '0) && !out_frame_ok_q && !out_header_ok_q && !out_power_on_q)
    else $error("short capture result carries nonzero fields");

  a_frame_and: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_frame_ok_q == (out_length_ok_q && out_header_ok_q
                                        && out_tail_ok_q && out_checksum_ok_q)))
    else $error("frame_ok disagrees with the individual checks");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> cap_start_q)
    else $error("capture did not restart after a final entry");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !res_load)
    else $error("pending result overwritten");

endmodule
